>>> rtl/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// Wilder RSI stream package
// Shared widths, result constants, opcodes and the command and status bundles
// that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package wrsi_pkg;

  localparam int unsigned DEF_MAX_PERIOD = 64;
  localparam int unsigned DEF_PRICE_BITS = 32;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned RSI_BITS   = 15;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned PRICE_IN_W = 32;

  localparam logic [CFG_W-1:0]    PERIOD_RESET = 7'd14;
  localparam logic [RSI_BITS-1:0] RSI_FIFTY    = 15'd12800;
  localparam logic [RSI_BITS-1:0] RSI_HUNDRED  = 15'd25600;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic capture;
    logic check;
    logic apply;
    logic mul;
    logic lane;
    logic div_start;
    logic div_wide;
    logic avg_wb;
    logic rsi_mul;
    logic rsi_wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic need_div;
    logic div_done;
    logic loss_zero;
  } sts_t;

endpackage

>>> rtl/wrsi_div.sv
// ----------------------------------------------------------------------------
// Wilder RSI shared divider
// Restoring divider with two modes. The narrow mode divides by the period and
// retires two quotient bits per cycle; the wide mode divides by the sum of the
// averages and retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrsi_div #(
  parameter int unsigned NUM_W   = 63,
  parameter int unsigned REM_W   = 49,
  parameter int unsigned LOW_W   = 48,
  parameter int unsigned PER_W   = 7,
  parameter int unsigned QW_WIDE = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             wide_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [REM_W-1:0] den_i,
  output logic             done_o,
  output logic [LOW_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(LOW_W + 1);

  logic             busy_q, done_q, wide_q;
  logic [CW-1:0]    cnt_q;
  logic [REM_W-1:0] rem_q, den_q, rem_w;
  logic [LOW_W-1:0] low_q, quo_q;
  logic [REM_W:0]   t_w;
  logic             ge_w;
  logic [PER_W-1:0] dn, r1, r2;
  logic [PER_W:0]   t1, t2;
  logic             ge1, ge2;

  always_comb begin
    t_w   = {rem_q, low_q[LOW_W-1]};
    ge_w  = t_w >= {1'b0, den_q};
    rem_w = ge_w ? REM_W'(t_w - {1'b0, den_q}) : REM_W'(t_w);
    dn    = den_q[PER_W-1:0];
    t1    = {rem_q[PER_W-1:0], low_q[LOW_W-1]};
    ge1   = t1 >= {1'b0, dn};
    r1    = ge1 ? PER_W'(t1 - {1'b0, dn}) : PER_W'(t1);
    t2    = {r1, low_q[LOW_W-2]};
    ge2   = t2 >= {1'b0, dn};
    r2    = ge2 ? PER_W'(t2 - {1'b0, dn}) : PER_W'(t2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= wide_i ? CW'(QW_WIDE) : CW'(LOW_W / 2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      wide_q <= wide_i;
      den_q  <= den_i;
      quo_q  <= '0;
      if (wide_i) begin
        rem_q <= REM_W'(num_i >> QW_WIDE);
        low_q <= LOW_W'(num_i[QW_WIDE-1:0]) << (LOW_W - QW_WIDE);
      end else begin
        rem_q <= REM_W'(num_i >> LOW_W);
        low_q <= num_i[LOW_W-1:0];
      end
    end else if (busy_q) begin
      if (wide_q) begin
        rem_q <= rem_w;
        low_q <= low_q << 1;
        quo_q <= {quo_q[LOW_W-2:0], ge_w};
      end else begin
        rem_q <= REM_W'(r2);
        low_q <= low_q << 2;
        quo_q <= {quo_q[LOW_W-3:0], ge1, ge2};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/wrsi_datapath.sv
// ----------------------------------------------------------------------------
// Wilder RSI datapath
// History registers, snapshot for revisions, average update arithmetic, the
// shared divider and the result registers, all driven by controller commands.
// ----------------------------------------------------------------------------
module wrsi_datapath #(
  parameter int unsigned MAX_PERIOD = wrsi_pkg::DEF_MAX_PERIOD,
  parameter int unsigned PRICE_BITS = wrsi_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrsi_pkg::cmd_t                      cmd_i,
  output wrsi_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [wrsi_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                opcode_i,
  input  logic signed [wrsi_pkg::STAMP_W-1:0] candle_time_i,
  input  logic [wrsi_pkg::PRICE_IN_W-1:0]     close_price_i,
  output logic [wrsi_pkg::RSI_BITS-1:0]       rsi_value_o,
  output logic                                warming_up_o,
  output logic                                was_revision_o
);

  localparam int unsigned AVG_W  = PRICE_BITS + wrsi_pkg::FRAC_BITS;
  localparam int unsigned AVG_WE = AVG_W + (AVG_W % 2);
  localparam int unsigned NUM_W  = AVG_W + wrsi_pkg::RSI_BITS;
  localparam int unsigned REM_W  = AVG_W + 1;
  localparam int unsigned PER_W  = $clog2(MAX_PERIOD + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_PERIOD + 2);
  localparam int unsigned CMP_W  = (PER_W > wrsi_pkg::CFG_W) ? PER_W : wrsi_pkg::CFG_W;
  localparam int unsigned RB     = wrsi_pkg::RSI_BITS;

  logic [wrsi_pkg::CFG_W-1:0]   lookback_q;
  logic [PRICE_BITS-1:0]        last_close_q, snap_close_q;
  logic [wrsi_pkg::STAMP_W-1:0] last_stamp_q, stamp_q;
  logic [CNT_W-1:0]             count_q, snap_count_q;
  logic [AVG_W-1:0]             gavg_q, lavg_q, snap_gain_q, snap_loss_q;

  logic                  op_q, init_q, warm_q, rev_q;
  logic [PRICE_BITS-1:0] price_q, xg_q, xl_q;
  logic [NUM_W-1:0]      prod_q;
  logic [REM_W-1:0]      total_q;
  logic [RB-1:0]         rsi_q, rsi_out_q;
  logic                  warm_out_q, rev_out_q;

  logic [CMP_W-1:0]         lb_ext;
  logic [PER_W-1:0]         p_eff, pm1;
  logic [CNT_W-1:0]         count_p;
  logic                     revision, need_div, clear_hist;
  logic [PRICE_BITS-1:0]    gain_x, loss_x, x_sel;
  logic [AVG_W-1:0]         avg_sel;
  logic [AVG_W+PER_W-1:0]   mul_w;
  logic [NUM_W-1:0]         addend, rsi_prod, div_num;
  logic [REM_W-1:0]         div_den;
  logic [AVG_WE-1:0]        quo;
  logic                     div_done;
  logic [RB-1:0]            rsi_quo;

  always_comb begin
    lb_ext = CMP_W'(lookback_q);
    if (lb_ext < CMP_W'(2)) begin
      p_eff = PER_W'(2);
    end else if (lb_ext > CMP_W'(MAX_PERIOD)) begin
      p_eff = PER_W'(MAX_PERIOD);
    end else begin
      p_eff = PER_W'(lb_ext);
    end
    pm1     = p_eff - PER_W'(1);
    count_p = CNT_W'(p_eff);

    revision   = (count_q != '0) && (stamp_q == last_stamp_q);
    need_div   = (count_q != '0) && (count_q >= count_p);
    clear_hist = cfg_we_i || (cmd_i.check && (op_q == wrsi_pkg::OP_CLEAR));

    if (price_q > last_close_q) begin
      gain_x = price_q - last_close_q;
      loss_x = '0;
    end else begin
      gain_x = '0;
      loss_x = last_close_q - price_q;
    end

    avg_sel  = cmd_i.lane ? lavg_q : gavg_q;
    x_sel    = cmd_i.lane ? xl_q : xg_q;
    mul_w    = avg_sel * pm1;
    addend   = (init_q ? NUM_W'(avg_sel) : NUM_W'(x_sel)) << wrsi_pkg::FRAC_BITS;
    rsi_prod = gavg_q * wrsi_pkg::RSI_HUNDRED;
    div_num  = cmd_i.div_wide ? prod_q : prod_q + addend;
    div_den  = cmd_i.div_wide ? total_q : REM_W'(p_eff);
    rsi_quo  = (quo[RB-1:0] > wrsi_pkg::RSI_HUNDRED) ? wrsi_pkg::RSI_HUNDRED : quo[RB-1:0];
  end

  wrsi_div #(
    .NUM_W  (NUM_W),
    .REM_W  (REM_W),
    .LOW_W  (AVG_WE),
    .PER_W  (PER_W),
    .QW_WIDE(RB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .wide_i (cmd_i.div_wide),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookback_q   <= wrsi_pkg::PERIOD_RESET;
      last_close_q <= '0;
      last_stamp_q <= '0;
      count_q      <= '0;
      gavg_q       <= '0;
      lavg_q       <= '0;
      snap_close_q <= '0;
      snap_gain_q  <= '0;
      snap_loss_q  <= '0;
      snap_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        lookback_q <= cfg_wdata_i;
      end
      if (clear_hist) begin
        last_close_q <= '0;
        last_stamp_q <= '0;
        count_q      <= '0;
        gavg_q       <= '0;
        lavg_q       <= '0;
        snap_close_q <= '0;
        snap_gain_q  <= '0;
        snap_loss_q  <= '0;
        snap_count_q <= '0;
      end else if (cmd_i.check && revision) begin
        last_close_q <= snap_close_q;
        gavg_q       <= snap_gain_q;
        lavg_q       <= snap_loss_q;
        count_q      <= snap_count_q;
      end else if (cmd_i.apply) begin
        snap_close_q <= last_close_q;
        snap_gain_q  <= gavg_q;
        snap_loss_q  <= lavg_q;
        snap_count_q <= count_q;
        last_stamp_q <= stamp_q;
        last_close_q <= price_q;
        if (count_q == '0) begin
          count_q <= CNT_W'(1);
        end else if (count_q <= count_p) begin
          gavg_q  <= gavg_q + AVG_W'(gain_x);
          lavg_q  <= lavg_q + AVG_W'(loss_x);
          count_q <= count_q + CNT_W'(1);
        end
      end else if (cmd_i.avg_wb) begin
        if (cmd_i.lane) begin
          lavg_q <= AVG_W'(quo);
        end else begin
          gavg_q <= AVG_W'(quo);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      stamp_q <= candle_time_i;
      price_q <= PRICE_BITS'(close_price_i);
    end
    if (cmd_i.check) begin
      rev_q  <= (op_q == wrsi_pkg::OP_PUSH) && revision;
      rsi_q  <= wrsi_pkg::RSI_FIFTY;
      warm_q <= 1'b1;
    end
    if (cmd_i.apply) begin
      xg_q   <= gain_x;
      xl_q   <= loss_x;
      init_q <= (count_q == count_p);
      warm_q <= !need_div;
    end
    if (cmd_i.mul) begin
      prod_q <= init_q ? '0 : NUM_W'(mul_w);
    end
    if (cmd_i.rsi_mul) begin
      prod_q  <= rsi_prod;
      total_q <= {1'b0, gavg_q} + {1'b0, lavg_q};
      if (lavg_q == '0) begin
        rsi_q <= wrsi_pkg::RSI_HUNDRED;
      end
    end
    if (cmd_i.rsi_wb) begin
      rsi_q <= rsi_quo;
    end
    if (cmd_i.out_load) begin
      rsi_out_q  <= rsi_q;
      warm_out_q <= warm_q;
      rev_out_q  <= rev_q;
    end
  end

  assign sts_o.is_clear  = (op_q == wrsi_pkg::OP_CLEAR);
  assign sts_o.need_div  = need_div;
  assign sts_o.div_done  = div_done;
  assign sts_o.loss_zero = (lavg_q == '0);

  assign rsi_value_o    = rsi_out_q;
  assign warming_up_o   = warm_out_q;
  assign was_revision_o = rev_out_q;

endmodule

>>> rtl/wrsi_ctrl.sv
// ----------------------------------------------------------------------------
// Wilder RSI controller
// Sequences one candle through check, update, the two average divisions and
// the ratio division, skipping the later steps for a clear, a warm-up candle or
// a zero average loss, and owns both channel handshakes.
module wrsi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  wrsi_pkg::sts_t sts_i,
  output wrsi_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_APPLY  = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_RMUL   = 4'd6;
  localparam logic [3:0] S_RSTART = 4'd7;
  localparam logic [3:0] S_RWAIT  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       lane_q, lane_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    lane_d        = lane_q;
    cmd_o         = '0;
    cmd_o.lane    = lane_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.is_clear ? S_OUT : S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        lane_d      = 1'b0;
        state_d     = sts_i.need_div ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.avg_wb = 1'b1;
          if (lane_q) begin
            state_d = S_RMUL;
          end else begin
            lane_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_RMUL: begin
        cmd_o.rsi_mul = 1'b1;
        state_d       = sts_i.loss_zero ? S_OUT : S_RSTART;
      end
      S_RSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_wide  = 1'b1;
        state_d         = S_RWAIT;
      end
      S_RWAIT: begin
        cmd_o.div_wide = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.rsi_wb = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/wilder_rsi_stream_unit.sv
// ----------------------------------------------------------------------------
// Wilder RSI stream unit
//
//   Channel   Handshake                  Payload
//   cfg       cfg_we_i                   cfg_wdata_i (lookback period)
//   in        in_valid_i / in_stall_o    opcode_i, candle_time_i, close_price_i
//   out       out_valid_o / out_stall_i  rsi_value_o, warming_up_o, was_revision_o
//
// One candle at a time. A clear skips the update, a warm-up candle skips the
// divisions, and a candle past warm-up uses the shared divider: two period
// divisions at two bits per cycle, then one ratio division at one bit per cycle,
// which is skipped at zero average loss. The input stalls until the result is
// loaded into the output register, which waits while a previous result there is
// stalled. Reset leaves the period at 14 and clears all history.
// ----------------------------------------------------------------------------
module wilder_rsi_stream_unit #(
  parameter int unsigned MAX_PERIOD = wrsi_pkg::DEF_MAX_PERIOD,
  parameter int unsigned PRICE_BITS = wrsi_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrsi_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [wrsi_pkg::STAMP_W-1:0] candle_time_i,
  input  logic [wrsi_pkg::PRICE_IN_W-1:0]     close_price_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wrsi_pkg::RSI_BITS-1:0]       rsi_value_o,
  output logic                                warming_up_o,
  output logic                                was_revision_o
);

  wrsi_pkg::cmd_t cmd;
  wrsi_pkg::sts_t sts;

  wrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wrsi_datapath #(
    .MAX_PERIOD(MAX_PERIOD),
    .PRICE_BITS(PRICE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .candle_time_i (candle_time_i),
    .close_price_i (close_price_i),
    .rsi_value_o   (rsi_value_o),
    .warming_up_o  (warming_up_o),
    .was_revision_o(was_revision_o)
  );

endmodule
